### hdl/prdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the priority ready / delay queue scheduler.
// No dependencies.
package prdq_pkg;

  localparam logic [2:0] OP_ENQ_READY   = 3'd0;
  localparam logic [2:0] OP_ENQ_DELAYED = 3'd1;
  localparam logic [2:0] OP_RERUN       = 3'd2;
  localparam logic [2:0] OP_DISPATCH    = 3'd3;
  localparam logic [2:0] OP_TICK        = 3'd4;

  localparam int RemW = 17;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic move;
    logic done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_dispatch;
    logic can_move;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] id;
  } rdy_ent_t;

  typedef struct packed {
    logic [RemW-1:0] remain;
    logic [7:0]      prio;
    logic [7:0]      id;
  } dly_ent_t;

endpackage

### hdl/priority_ready_and_delay_queue_scheduler.sv
`timescale 1ns / 1ps
// Top level of the priority ready / delay queue scheduler.
// Depends on prdq_pkg, prdq_ctrl, prdq_datapath.
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with out_strobe high; the receiver
// cannot stall it, so sample it on that cycle. A request is captured, then
// executed, then shows its result. A dispatch also checks the delay queue
// head and moves each expired task from the delay queue head into the ready
// queue (up to QUEUE_DEPTH) while the ready queue has room, before the result.
// Each queue is a row of registered cells; a sorted insert, pop or tick
// updates every cell in the same cycle, so the expiry moves set the rate.
// Opcodes: 0 enqueue ready, 1 enqueue delayed (stored as delay + 1),
// 2 rerun the last dispatched task (ready if delay is 0, else delayed),
// 3 dispatch, 4 tick; 5..7 leave state alone. A full queue drops the insert
// and raises out_insert_dropped. Counts are reported in 5 bits.
module priority_ready_and_delay_queue_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_task_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_delay_ticks,
  output logic        out_strobe,
  output logic        out_dispatch_valid,
  output logic [7:0]  out_task_id,
  output logic [7:0]  out_priority,
  output logic        out_insert_dropped,
  output logic [4:0]  out_ready_count,
  output logic [4:0]  out_delayed_count
);

  prdq_pkg::ctrl_cmd_t cmd;
  prdq_pkg::dp_stat_t  stat;

  // sequencer
  prdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // queues and result registers
  prdq_datapath #(.DEPTH(QUEUE_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .in_delay_ticks  (in_delay_ticks),
    .stat            (stat),
    .res_valid       (out_dispatch_valid),
    .res_id          (out_task_id),
    .res_prio        (out_priority),
    .res_drop        (out_insert_dropped),
    .rdy_cnt         (out_ready_count),
    .dly_cnt         (out_delayed_count)
  );

  // result cycle
  assign out_strobe = cmd.done;

endmodule

### hdl/prdq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the scheduler: accept, execute, expiry moves, result.
// Depends on prdq_pkg.
module prdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  prdq_pkg::dp_stat_t  stat,
  output prdq_pkg::ctrl_cmd_t cmd,
  output logic                busy
);

  prdq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prdq_pkg::ST_IDLE: begin
        if (start) state_nxt = prdq_pkg::ST_EXEC;
      end
      prdq_pkg::ST_EXEC: begin
        state_nxt = stat.is_dispatch ? prdq_pkg::ST_MOVE : prdq_pkg::ST_DONE;
      end
      prdq_pkg::ST_MOVE: begin
        if (!stat.can_move) state_nxt = prdq_pkg::ST_DONE;
      end
      prdq_pkg::ST_DONE: begin
        state_nxt = prdq_pkg::ST_IDLE;
      end
      default: state_nxt = prdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      prdq_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      prdq_pkg::ST_EXEC: cmd.exec = 1'b1;
      prdq_pkg::ST_MOVE: cmd.move = stat.can_move;
      prdq_pkg::ST_DONE: cmd.done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

### hdl/prdq_datapath.sv
`timescale 1ns / 1ps
// Queue cells, request and result registers of the scheduler.
// Depends on prdq_pkg.
module prdq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prdq_pkg::ctrl_cmd_t cmd,
  input  logic [2:0]          in_opcode,
  input  logic [7:0]          in_task_id,
  input  logic [7:0]          in_priority_req,
  input  logic [15:0]         in_delay_ticks,
  output prdq_pkg::dp_stat_t  stat,
  output logic                res_valid,
  output logic [7:0]          res_id,
  output logic [7:0]          res_prio,
  output logic                res_drop,
  output logic [4:0]          rdy_cnt,
  output logic [4:0]          dly_cnt
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  // request registers
  logic [2:0]  op_r;
  logic [7:0]  id_r, prio_r;
  logic [15:0] ticks_r;

  prdq_pkg::rdy_ent_t rdy_r [DEPTH];
  prdq_pkg::rdy_ent_t rdy_nxt [DEPTH];
  prdq_pkg::dly_ent_t dly_r [DEPTH];
  prdq_pkg::dly_ent_t dly_nxt [DEPTH];
  logic [CW-1:0] rsz_r, rsz_nxt, dsz_r, dsz_nxt;
  prdq_pkg::rdy_ent_t last_r, last_nxt;
  logic valid_r, valid_nxt, drop_r, drop_nxt;
  logic [7:0] oid_r, oid_nxt, oprio_r, oprio_nxt;

  // operation decode
  logic r_ins, r_pop, d_ins, d_pop, d_tick;
  prdq_pkg::rdy_ent_t r_new;
  prdq_pkg::dly_ent_t d_new;
  logic [DEPTH-1:0] r_ge, d_le;
  logic [31:0] rsz_w, dsz_w;

  always_comb begin
    r_ins = 1'b0; r_pop = 1'b0; d_ins = 1'b0; d_pop = 1'b0; d_tick = 1'b0;
    drop_nxt = drop_r;
    r_new = '{prio: prio_r, id: id_r};
    d_new = '{remain: prdq_pkg::RemW'(ticks_r) + 1'b1, prio: prio_r, id: id_r};
    if (cmd.exec) begin
      drop_nxt = 1'b0;
      case (op_r)
        prdq_pkg::OP_ENQ_READY: begin
          r_ins = (rsz_r != Full); drop_nxt = (rsz_r == Full);
        end
        prdq_pkg::OP_ENQ_DELAYED: begin
          d_ins = (dsz_r != Full); drop_nxt = (dsz_r == Full);
        end
        prdq_pkg::OP_RERUN: begin
          r_new = last_r;
          d_new.prio = last_r.prio;
          d_new.id   = last_r.id;
          if (ticks_r == 16'd0) begin
            r_ins = (rsz_r != Full); drop_nxt = (rsz_r == Full);
          end else begin
            d_ins = (dsz_r != Full); drop_nxt = (dsz_r == Full);
          end
        end
        prdq_pkg::OP_DISPATCH: r_pop = (rsz_r != '0);
        prdq_pkg::OP_TICK:     d_tick = 1'b1;
        default: ;
      endcase
    end else if (cmd.move) begin
      r_ins = 1'b1;
      d_pop = 1'b1;
      r_new = '{prio: dly_r[0].prio, id: dly_r[0].id};
    end
  end

  // ready and delay queue cells: sorted insert, head pop, tick
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      r_ge[k] = (CW'(k) < rsz_r) && (rdy_r[k].prio >= r_new.prio);
      d_le[k] = (CW'(k) < dsz_r) && (dly_r[k].remain <= d_new.remain);
    end
    for (int k = 0; k < DEPTH; k++) begin
      rdy_nxt[k] = rdy_r[k];
      dly_nxt[k] = dly_r[k];
    end
    if (r_ins) begin
      if (!r_ge[0]) rdy_nxt[0] = r_new;
      for (int k = 1; k < DEPTH; k++) begin
        if (!r_ge[k]) rdy_nxt[k] = r_ge[k-1] ? r_new : rdy_r[k-1];
      end
    end else if (r_pop) begin
      for (int k = 0; k < DEPTH - 1; k++) rdy_nxt[k] = rdy_r[k+1];
    end
    if (d_ins) begin
      if (!d_le[0]) dly_nxt[0] = d_new;
      for (int k = 1; k < DEPTH; k++) begin
        if (!d_le[k]) dly_nxt[k] = d_le[k-1] ? d_new : dly_r[k-1];
      end
    end else if (d_pop) begin
      for (int k = 0; k < DEPTH - 1; k++) dly_nxt[k] = dly_r[k+1];
    end else if (d_tick) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (dly_r[k].remain != '0) dly_nxt[k].remain = dly_r[k].remain - 1'b1;
      end
    end
  end

  always_comb begin
    rsz_nxt = rsz_r;
    dsz_nxt = dsz_r;
    if (r_ins) rsz_nxt = rsz_r + 1'b1;
    else if (r_pop) rsz_nxt = rsz_r - 1'b1;
    if (d_ins) dsz_nxt = dsz_r + 1'b1;
    else if (d_pop) dsz_nxt = dsz_r - 1'b1;
    last_nxt  = r_pop ? rdy_r[0] : last_r;
    valid_nxt = cmd.exec ? r_pop : valid_r;
    oid_nxt   = cmd.exec ? (r_pop ? rdy_r[0].id : 8'd0) : oid_r;
    oprio_nxt = cmd.exec ? (r_pop ? rdy_r[0].prio : 8'd0) : oprio_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsz_r  <= '0;
      dsz_r  <= '0;
      last_r <= '0;
    end else begin
      rsz_r  <= rsz_nxt;
      dsz_r  <= dsz_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      id_r    <= in_task_id;
      prio_r  <= in_priority_req;
      ticks_r <= in_delay_ticks;
    end
    for (int k = 0; k < DEPTH; k++) begin
      rdy_r[k] <= rdy_nxt[k];
      dly_r[k] <= dly_nxt[k];
    end
    valid_r <= valid_nxt;
    drop_r  <= drop_nxt;
    oid_r   <= oid_nxt;
    oprio_r <= oprio_nxt;
  end

  assign stat.is_dispatch = (op_r == prdq_pkg::OP_DISPATCH);
  assign stat.can_move    = (dsz_r != '0) && (dly_r[0].remain == '0) && (rsz_r != Full);

  assign rsz_w     = 32'(rsz_r);
  assign dsz_w     = 32'(dsz_r);
  assign rdy_cnt   = rsz_w[4:0];
  assign dly_cnt   = dsz_w[4:0];
  assign res_valid = valid_r;
  assign res_id    = oid_r;
  assign res_prio  = oprio_r;
  assign res_drop  = drop_r;

endmodule

### hdl/prdq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the scheduler, bound to the top level.
// Depends on priority_ready_and_delay_queue_scheduler.
module prdq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_dispatch_valid,
  input logic       out_insert_dropped
);

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken but not busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result outside a request");

  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe) else $error("result repeated");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_dispatch_valid && out_insert_dropped))
    else $error("dispatch and drop together");

endmodule

bind priority_ready_and_delay_queue_scheduler prdq_checker u_prdq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_dispatch_valid (out_dispatch_valid),
  .out_insert_dropped (out_insert_dropped)
);
